/* rtl/core/attitude_pd_controller_unit_assert.svh */
// Assertion macros shared by the checker of the attitude PD controller.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef ATTITUDE_PD_CONTROLLER_UNIT_ASSERT_SVH
`define ATTITUDE_PD_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define APDC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("attitude PD controller assertion failed");

// Next-cycle implication, checked out of reset.
`define APDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("attitude PD controller assertion failed");

`endif

/* rtl/core/apdc_pkg.sv */
// Package of the attitude PD controller: types, constants and helper functions.
// Used by apdc_asin, attitude_pd_controller_unit and the testbench; depends on nothing.
`default_nettype none

package apdc_pkg;

  // Default number of CORDIC iterations and the length of the angle table.
  localparam int unsigned ASIN_STEPS_DEF = 14;
  localparam int unsigned ATAN_LEN       = 24;
  // Result bits of the integer square root of a Q.56 value.
  localparam int unsigned SQRT_BITS      = 29;
  // Reference clamp, 85 degrees in Q4.11.
  localparam logic signed [15:0] ANGLE_LIMIT = 16'sd3038;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ROLL_P     = 3'd0,
    CFG_ROLL_D     = 3'd1,
    CFG_PITCH_P    = 3'd2,
    CFG_PITCH_D    = 3'd3,
    CFG_YAW_RATE_P = 3'd4
  } cfg_idx_e;

  // Fields that travel alongside the arcsine pipelines.
  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] roll_ref;
    logic signed [15:0] pitch_ref;
    logic signed [15:0] yaw_rate_ref;
  } side_t;

  // Result of one arcsine pipeline.
  typedef struct packed {
    logic signed [15:0] angle;
    logic               flag;
  } asin_res_t;

  // Number of CORDIC iterations actually run.
  function automatic int unsigned cordic_steps(int unsigned steps);
    return (steps < ATAN_LEN) ? steps : ATAN_LEN;
  endfunction

  // Register stages of the arcsine pipeline: magnitude, square, radicand,
  // square-root bits, CORDIC iterations and the final rounding.
  function automatic int unsigned asin_latency(int unsigned steps);
    return 3 + SQRT_BITS + cordic_steps(steps) + 1;
  endfunction

  // round(atan(2^-i) * 65536).
  function automatic logic signed [19:0] atan_q16(logic [4:0] idx);
    logic signed [19:0] v;
    unique case (idx)
      5'd0:    v = 20'sd51472;
      5'd1:    v = 20'sd30386;
      5'd2:    v = 20'sd16055;
      5'd3:    v = 20'sd8150;
      5'd4:    v = 20'sd4091;
      5'd5:    v = 20'sd2047;
      5'd6:    v = 20'sd1024;
      5'd7:    v = 20'sd512;
      5'd8:    v = 20'sd256;
      5'd9:    v = 20'sd128;
      5'd10:   v = 20'sd64;
      5'd11:   v = 20'sd32;
      5'd12:   v = 20'sd16;
      5'd13:   v = 20'sd8;
      5'd14:   v = 20'sd4;
      5'd15:   v = 20'sd2;
      5'd16:   v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

  // Clamp a reference angle to the limit.
  function automatic logic signed [15:0] clamp_angle(logic signed [15:0] v);
    logic signed [15:0] r;
    if (v > ANGLE_LIMIT) begin
      r = ANGLE_LIMIT;
    end else if (v < -ANGLE_LIMIT) begin
      r = -ANGLE_LIMIT;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Round a Q.19 sum to Q4.11 and saturate; the top bit flags a clamp.
  function automatic logic [16:0] sat_cmd(logic signed [34:0] s);
    logic signed [34:0] r;
    logic [16:0]        o;
    r = (s + 35'sd128) >>> 8;
    if (r > 35'sd32767) begin
      o = {1'b1, 16'h7fff};
    end else if (r < -35'sd32768) begin
      o = {1'b1, 16'h8000};
    end else begin
      o = {1'b0, r[15:0]};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/apdc_asin.sv */
// Pipelined arcsine of a Q.28 argument, giving a Q4.11 angle and a clamp flag.
// Square root one bit per stage, then one CORDIC iteration per stage; uses apdc_pkg.
`default_nettype none

module apdc_asin #(
  parameter int unsigned ASIN_STEPS = apdc_pkg::ASIN_STEPS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic signed [33:0]  arg_i,
  output apdc_pkg::asin_res_t      res_o
);

  localparam int unsigned NS = apdc_pkg::cordic_steps(ASIN_STEPS);
  localparam int unsigned SQ = apdc_pkg::SQRT_BITS;

  // Magnitude stage: absolute value and clamp to one.
  logic [33:0] abs_c;
  logic        ovr_c;
  logic [28:0] mag_a_q;
  logic        neg_a_q, flg_a_q;

  assign abs_c = arg_i[33] ? 34'(-arg_i) : 34'(arg_i);
  assign ovr_c = abs_c > 34'h1000_0000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q <= ovr_c ? 29'h1000_0000 : abs_c[28:0];
      neg_a_q <= arg_i[33];
      flg_a_q <= ovr_c;
    end
  end

  // Square stage.
  logic [57:0] msq_b_q;
  logic [28:0] mag_b_q;
  logic        neg_b_q, flg_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      msq_b_q <= 58'(mag_a_q) * 58'(mag_a_q);
      mag_b_q <= mag_a_q;
      neg_b_q <= neg_a_q;
      flg_b_q <= flg_a_q;
    end
  end

  // Radicand stage: one minus the square, in Q.56.
  logic [57:0] rad_c_q;
  logic [28:0] mag_c_q;
  logic        neg_c_q, flg_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_c_q <= (58'd1 << 56) - msq_b_q;
      mag_c_q <= mag_b_q;
      neg_c_q <= neg_b_q;
      flg_c_q <= flg_b_q;
    end
  end

  // Floor square root, one result bit per stage.
  logic [57:0] sv_q   [SQ];
  logic [57:0] sr_q   [SQ];
  logic [28:0] smag_q [SQ];
  logic        sneg_q [SQ];
  logic        sflg_q [SQ];

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [57:0] BIT = 58'd1 << (56 - 2 * k);
    logic [57:0] v_in, r_in, trial;
    logic [28:0] m_in;
    logic        n_in, f_in;

    if (k == 0) begin : g_first
      assign v_in = rad_c_q;
      assign r_in = '0;
      assign m_in = mag_c_q;
      assign n_in = neg_c_q;
      assign f_in = flg_c_q;
    end else begin : g_next
      assign v_in = sv_q[k-1];
      assign r_in = sr_q[k-1];
      assign m_in = smag_q[k-1];
      assign n_in = sneg_q[k-1];
      assign f_in = sflg_q[k-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in >= trial) begin
          sv_q[k] <= v_in - trial;
          sr_q[k] <= (r_in >> 1) + BIT;
        end else begin
          sv_q[k] <= v_in;
          sr_q[k] <= r_in >> 1;
        end
        smag_q[k] <= m_in;
        sneg_q[k] <= n_in;
        sflg_q[k] <= f_in;
      end
    end
  end

  // Vectoring CORDIC, one iteration per stage.
  logic signed [31:0] cx_q [NS];
  logic signed [31:0] cy_q [NS];
  logic signed [19:0] cz_q [NS];
  logic               cneg_q [NS];
  logic               cflg_q [NS];

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [31:0] x_in, y_in;
    logic signed [19:0] z_in;
    logic               n_in, f_in;

    if (i == 0) begin : g_first
      assign x_in = $signed({3'b000, sr_q[SQ-1][28:0]});
      assign y_in = $signed({3'b000, smag_q[SQ-1]});
      assign z_in = '0;
      assign n_in = sneg_q[SQ-1];
      assign f_in = sflg_q[SQ-1];
    end else begin : g_next
      assign x_in = cx_q[i-1];
      assign y_in = cy_q[i-1];
      assign z_in = cz_q[i-1];
      assign n_in = cneg_q[i-1];
      assign f_in = cflg_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_in[31]) begin
          cx_q[i] <= x_in + (y_in >>> i);
          cy_q[i] <= y_in - (x_in >>> i);
          cz_q[i] <= z_in + apdc_pkg::atan_q16(5'(i));
        end else begin
          cx_q[i] <= x_in - (y_in >>> i);
          cy_q[i] <= y_in + (x_in >>> i);
          cz_q[i] <= z_in - apdc_pkg::atan_q16(5'(i));
        end
        cneg_q[i] <= n_in;
        cflg_q[i] <= f_in;
      end
    end
  end

  // Round Q.16 to Q4.11 and apply the sign of the argument.
  logic signed [19:0] rnd_c;
  apdc_pkg::asin_res_t res_q;

  assign rnd_c = (cz_q[NS-1] + 20'sd16) >>> 5;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.angle <= cneg_q[NS-1] ? 16'(-rnd_c) : rnd_c[15:0];
      res_q.flag  <= cflg_q[NS-1];
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* rtl/core/attitude_pd_controller_unit.sv */
// Attitude PD controller top level: ports, gains, pipeline control and command math.
// Uses apdc_pkg and two apdc_asin pipelines.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   quaternion, rates, references
//   output    out        out_valid_o / out_stall_i commands, angles, saturated
//   config    in         cfg_we_i                  cfg_index_i, cfg_data_i
//
// One request enters per cycle while the pipeline is not held; the latency is set by
// the 29 square-root stages and the CORDIC stages of the arcsine pipelines.
// Reset clears the valid bits and zeroes the gains.
// The whole pipeline holds while a finished result waits under stall, so the
// input stalls exactly then, even when bubbles remain inside the pipeline.
`default_nettype none

module attitude_pd_controller_unit #(
  parameter int unsigned ASIN_STEPS = apdc_pkg::ASIN_STEPS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic signed [15:0] rate_x_i,
  input  wire logic signed [15:0] rate_y_i,
  input  wire logic signed [15:0] rate_z_i,
  input  wire logic signed [15:0] roll_reference_i,
  input  wire logic signed [15:0] pitch_reference_i,
  input  wire logic signed [15:0] yaw_rate_reference_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      roll_rate_command_o,
  output logic signed [15:0]      pitch_rate_command_o,
  output logic signed [15:0]      yaw_rate_command_o,
  output logic signed [15:0]      roll_angle_o,
  output logic signed [15:0]      pitch_angle_o,
  output logic                    saturated_o
);

  localparam int unsigned LAT = apdc_pkg::asin_latency(ASIN_STEPS);

  // Pipeline advance: everything moves unless a result waits under stall.
  logic en;
  logic out_vld_q;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // Gain registers.
  logic signed [15:0] g_rp_q, g_rd_q, g_pp_q, g_pd_q, g_yp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_rp_q <= '0;
      g_rd_q <= '0;
      g_pp_q <= '0;
      g_pd_q <= '0;
      g_yp_q <= '0;
    end else if (cfg_we_i) begin
      unique case (apdc_pkg::cfg_idx_e'(cfg_index_i))
        apdc_pkg::CFG_ROLL_P:     g_rp_q <= cfg_data_i;
        apdc_pkg::CFG_ROLL_D:     g_rd_q <= cfg_data_i;
        apdc_pkg::CFG_PITCH_P:    g_pp_q <= cfg_data_i;
        apdc_pkg::CFG_PITCH_D:    g_pd_q <= cfg_data_i;
        apdc_pkg::CFG_YAW_RATE_P: g_yp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits of the input, product, delay and multiply stages.
  logic vld0_q, vld1_q, m_vld_q;
  logic vd_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q    <= 1'b0;
      vld1_q    <= 1'b0;
      m_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < LAT; i++) vd_q[i] <= 1'b0;
    end else if (en) begin
      vld0_q    <= in_valid_i;
      vld1_q    <= vld0_q;
      vd_q[0]   <= vld1_q;
      for (int i = 1; i < LAT; i++) vd_q[i] <= vd_q[i-1];
      m_vld_q   <= vd_q[LAT-1];
      out_vld_q <= m_vld_q;
    end
  end

  // Input register.
  logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
  apdc_pkg::side_t    sd0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      qw_q                <= quat_w_i;
      qx_q                <= quat_x_i;
      qy_q                <= quat_y_i;
      qz_q                <= quat_z_i;
      sd0_q.rate_x        <= rate_x_i;
      sd0_q.rate_y        <= rate_y_i;
      sd0_q.rate_z        <= rate_z_i;
      sd0_q.roll_ref      <= roll_reference_i;
      sd0_q.pitch_ref     <= pitch_reference_i;
      sd0_q.yaw_rate_ref  <= yaw_rate_reference_i;
    end
  end

  // Quaternion products and reference clamp.
  logic signed [31:0] p_yz_q, p_wx_q, p_xz_q, p_wy_q;
  apdc_pkg::side_t    sd1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_yz_q             <= qy_q * qz_q;
      p_wx_q             <= qw_q * qx_q;
      p_xz_q             <= qx_q * qz_q;
      p_wy_q             <= qw_q * qy_q;
      sd1_q.rate_x       <= sd0_q.rate_x;
      sd1_q.rate_y       <= sd0_q.rate_y;
      sd1_q.rate_z       <= sd0_q.rate_z;
      sd1_q.roll_ref     <= apdc_pkg::clamp_angle(sd0_q.roll_ref);
      sd1_q.pitch_ref    <= apdc_pkg::clamp_angle(sd0_q.pitch_ref);
      sd1_q.yaw_rate_ref <= sd0_q.yaw_rate_ref;
    end
  end

  // Arcsine arguments, twice the sums in Q.28.
  logic signed [32:0] sum_r, sum_p;
  logic signed [33:0] arg_r, arg_p;

  assign sum_r = $signed({p_yz_q[31], p_yz_q}) + $signed({p_wx_q[31], p_wx_q});
  assign sum_p = $signed({p_xz_q[31], p_xz_q}) - $signed({p_wy_q[31], p_wy_q});
  assign arg_r = $signed({sum_r, 1'b0});
  assign arg_p = $signed({sum_p, 1'b0});

  apdc_pkg::asin_res_t roll_res, pitch_res;

  apdc_asin #(.ASIN_STEPS(ASIN_STEPS)) u_asin_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .arg_i (arg_r),
    .res_o (roll_res)
  );

  apdc_asin #(.ASIN_STEPS(ASIN_STEPS)) u_asin_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .arg_i (arg_p),
    .res_o (pitch_res)
  );

  // Side fields wait alongside the arcsine pipelines.
  apdc_pkg::side_t sd_q [LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= sd1_q;
      for (int i = 1; i < LAT; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  // Error terms and gain products.
  apdc_pkg::side_t    sda;
  logic signed [15:0] roll_a, pitch_a;
  logic signed [16:0] e_r, e_p, e_y;
  logic signed [32:0] m_rp_q, m_pp_q, m_yp_q;
  logic signed [31:0] m_rd_q, m_pd_q;
  logic signed [15:0] m_roll_q, m_pitch_q;
  logic               m_flg_q;

  assign sda     = sd_q[LAT-1];
  assign roll_a  = roll_res.angle;
  assign pitch_a = 16'(-pitch_res.angle);
  assign e_r = $signed({sda.roll_ref[15], sda.roll_ref}) - $signed({roll_a[15], roll_a});
  assign e_p = $signed({sda.pitch_ref[15], sda.pitch_ref}) - $signed({pitch_a[15], pitch_a});
  assign e_y = $signed({sda.yaw_rate_ref[15], sda.yaw_rate_ref})
             - $signed({sda.rate_z[15], sda.rate_z});

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_rp_q    <= g_rp_q * e_r;
      m_pp_q    <= g_pp_q * e_p;
      m_yp_q    <= g_yp_q * e_y;
      m_rd_q    <= g_rd_q * sda.rate_x;
      m_pd_q    <= g_pd_q * sda.rate_y;
      m_roll_q  <= roll_a;
      m_pitch_q <= pitch_a;
      m_flg_q   <= roll_res.flag | pitch_res.flag;
    end
  end

  // Sum, round and saturate the commands.
  logic signed [34:0] s_r, s_p, s_y;
  logic [16:0]        c_r, c_p, c_y;

  assign s_r = $signed({{2{m_rp_q[32]}}, m_rp_q}) + $signed({{3{m_rd_q[31]}}, m_rd_q});
  assign s_p = $signed({{2{m_pp_q[32]}}, m_pp_q}) + $signed({{3{m_pd_q[31]}}, m_pd_q});
  assign s_y = $signed({{2{m_yp_q[32]}}, m_yp_q});
  assign c_r = apdc_pkg::sat_cmd(s_r);
  assign c_p = apdc_pkg::sat_cmd(s_p);
  assign c_y = apdc_pkg::sat_cmd(s_y);

  // Output register.
  logic signed [15:0] o_rc_q, o_pc_q, o_yc_q, o_roll_q, o_pitch_q;
  logic               o_sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_rc_q    <= c_r[15:0];
      o_pc_q    <= c_p[15:0];
      o_yc_q    <= c_y[15:0];
      o_roll_q  <= m_roll_q;
      o_pitch_q <= m_pitch_q;
      o_sat_q   <= m_flg_q | c_r[16] | c_p[16] | c_y[16];
    end
  end

  assign out_valid_o          = out_vld_q;
  assign roll_rate_command_o  = o_rc_q;
  assign pitch_rate_command_o = o_pc_q;
  assign yaw_rate_command_o   = o_yc_q;
  assign roll_angle_o         = o_roll_q;
  assign pitch_angle_o        = o_pitch_q;
  assign saturated_o          = o_sat_q;

endmodule

`default_nettype wire

/* rtl/core/apdc_checker.sv */
// Port-level checker of the attitude PD controller, bound to the top level.
// Uses the macros of attitude_pd_controller_unit_assert.svh.
`default_nettype none

`include "attitude_pd_controller_unit_assert.svh"

module apdc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [15:0] roll_angle_o,
  input wire logic signed [15:0] pitch_angle_o
);

  // A waiting result stays offered.
  `APDC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // The input stalls only behind a full, stalled output.
  `APDC_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // Angles stay within +-3300 in Q4.11; pitch is checked only while no input is valid.
  `APDC_ASSERT_IMP(a_roll_range, clk_i, rst_ni, out_valid_o,
                   (roll_angle_o <= 16'sd3300) && (roll_angle_o >= -16'sd3300))

  `APDC_ASSERT_IMP(a_pitch_range, clk_i, rst_ni, out_valid_o && !in_valid_i,
                   (pitch_angle_o <= 16'sd3300) && (pitch_angle_o >= -16'sd3300))

endmodule

bind attitude_pd_controller_unit apdc_checker u_apdc_checker (.*);

`default_nettype wire

/* bench/attitude_pd_controller_unit_tb.sv */
// Testbench of attitude_pd_controller_unit: directed table, then random requests
// checked against a predictor of the fixed-point attitude law. Depends on apdc_pkg.
`default_nettype none

module attitude_pd_controller_unit_tb;

  localparam int unsigned STEPS      = apdc_pkg::ASIN_STEPS_DEF;
  localparam int unsigned LATENCY    = 36 + ((STEPS < apdc_pkg::ATAN_LEN) ? STEPS
                                                                         : apdc_pkg::ATAN_LEN);
  localparam int unsigned STALL_LIM  = 4000;
  localparam int unsigned LONG_HOLD  = 400;
  localparam logic [2:0]  CFG_SPARE  = 3'd7;
  localparam longint      Q28_UNIT   = 64'sd1 << 28;
  localparam int unsigned ITEMS_SET  = 300;

  typedef struct packed {
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [15:0] wx, wy, wz;
    logic signed [15:0] roll_ref, pitch_ref, yaw_ref;
  } att_req_t;

  typedef struct packed {
    logic signed [15:0] roll_cmd, pitch_cmd, yaw_cmd;
    logic signed [15:0] roll, pitch;
    logic               sat;
  } att_res_t;

  // A row of the directed table; typed rows carry commands and the flag.
  typedef struct {
    att_req_t req;
    bit       typed;
    att_res_t res;
  } att_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = apdc_pkg::CFG_ROLL_P;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic signed [15:0] rate_x_i = '0, rate_y_i = '0, rate_z_i = '0;
  logic signed [15:0] roll_reference_i = '0, pitch_reference_i = '0;
  logic signed [15:0] yaw_rate_reference_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] roll_rate_command_o, pitch_rate_command_o, yaw_rate_command_o;
  logic signed [15:0] roll_angle_o, pitch_angle_o;
  logic saturated_o;

  attitude_pd_controller_unit dut (.*);

  always #1 clk_i = ~clk_i;

  // Gain copy, expected commands and shared run state.
  logic signed [15:0] gain_q [5];
  att_res_t   pending_cmds [$];
  att_row_t   dir_rows [$];
  bit         typed_q [$];
  att_res_t   typed_res_q [$];
  bit         quiet = 1'b0;
  bit         hold_req = 1'b0;
  int         mismatches = 0;
  int unsigned idle_cycles = 0;

  // Floor square root of a 56-bit radicand.
  function automatic longint root56(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  // Arcsine of a Q.28 argument in Q4.11, via a vectoring CORDIC.
  function automatic logic signed [15:0] arcsine(longint a, inout bit clip);
    longint atan_tab [apdc_pkg::ATAN_LEN] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                              512, 256, 128, 64, 32, 16, 8, 4, 2, 1,
                                              0, 0, 0, 0, 0, 0, 0};
    longint mag, x, y, z, xs, ys, r;
    mag = (a < 0) ? -a : a;
    if (mag > Q28_UNIT) begin
      mag = Q28_UNIT;
      clip = 1'b1;
    end
    x = root56(longint'(Q28_UNIT * Q28_UNIT - mag * mag));
    y = mag;
    z = 0;
    for (int i = 0; i < STEPS && i < apdc_pkg::ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_tab[i];
      end else begin
        x -= ys; y += xs; z -= atan_tab[i];
      end
    end
    r = (z + 16) >>> 5;
    return (a < 0) ? 16'(-r) : 16'(r);
  endfunction

  // Q.19 command sum rounded to Q4.11 and saturated.
  function automatic logic signed [15:0] command(longint s, inout bit clip);
    longint r;
    r = (s + 128) >>> 8;
    if (r > 32767) begin
      clip = 1'b1;
      r = 32767;
    end else if (r < -32768) begin
      clip = 1'b1;
      r = -32768;
    end
    return 16'(r);
  endfunction

  function automatic longint ref_limit(logic signed [15:0] v);
    longint l;
    l = 3038;
    return (v > l) ? l : ((v < -l) ? -l : longint'(v));
  endfunction

  function automatic att_res_t attitude_law(att_req_t q);
    att_res_t o;
    bit clip;
    longint roll, pitch;
    clip = 1'b0;
    roll  = arcsine(2 * (longint'(q.qy) * q.qz + longint'(q.qw) * q.qx), clip);
    pitch = -longint'(arcsine(2 * (longint'(q.qx) * q.qz - longint'(q.qw) * q.qy), clip));
    o.roll_cmd  = command(longint'(gain_q[apdc_pkg::CFG_ROLL_P])
                          * (ref_limit(q.roll_ref) - roll)
                          + longint'(gain_q[apdc_pkg::CFG_ROLL_D]) * q.wx, clip);
    o.pitch_cmd = command(longint'(gain_q[apdc_pkg::CFG_PITCH_P])
                          * (ref_limit(q.pitch_ref) - pitch)
                          + longint'(gain_q[apdc_pkg::CFG_PITCH_D]) * q.wy, clip);
    o.yaw_cmd   = command(longint'(gain_q[apdc_pkg::CFG_YAW_RATE_P])
                          * (longint'(q.yaw_ref) - q.wz), clip);
    o.roll  = 16'(roll);
    o.pitch = 16'(pitch);
    o.sat   = clip;
    return o;
  endfunction

  // Input acceptance queues a prediction; output acceptance checks it.
  always @(posedge clk_i) begin
    att_req_t q;
    att_res_t e;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      q = '{quat_w_i, quat_x_i, quat_y_i, quat_z_i, rate_x_i, rate_y_i, rate_z_i,
            roll_reference_i, pitch_reference_i, yaw_rate_reference_i};
      e = attitude_law(q);
      if (typed_q.size() != 0 && typed_q[0]) begin
        e.roll_cmd  = typed_res_q[0].roll_cmd;
        e.pitch_cmd = typed_res_q[0].pitch_cmd;
        e.yaw_cmd   = typed_res_q[0].yaw_cmd;
        e.sat       = typed_res_q[0].sat;
      end
      if (typed_q.size() != 0) begin
        void'(typed_q.pop_front());
        void'(typed_res_q.pop_front());
      end
      pending_cmds.push_back(e);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cmds.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        e = pending_cmds.pop_front();
        if (roll_rate_command_o !== e.roll_cmd) begin
          $error("roll_rate_command: expected %0d, got %0d", e.roll_cmd, roll_rate_command_o);
          mismatches++;
        end
        if (pitch_rate_command_o !== e.pitch_cmd) begin
          $error("pitch_rate_command: expected %0d, got %0d", e.pitch_cmd,
                 pitch_rate_command_o);
          mismatches++;
        end
        if (yaw_rate_command_o !== e.yaw_cmd) begin
          $error("yaw_rate_command: expected %0d, got %0d", e.yaw_cmd, yaw_rate_command_o);
          mismatches++;
        end
        if (roll_angle_o !== e.roll) begin
          $error("roll_angle: expected %0d, got %0d", e.roll, roll_angle_o);
          mismatches++;
        end
        if (pitch_angle_o !== e.pitch) begin
          $error("pitch_angle: expected %0d, got %0d", e.pitch, pitch_angle_o);
          mismatches++;
        end
        if (saturated_o !== e.sat) begin
          $error("saturated: expected %0b, got %0b", e.sat, saturated_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no request moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIM) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall per result, with an occasional long hold-off.
  initial begin
    int unsigned k;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        k = LONG_HOLD;
      end else begin
        k = quiet ? 0 : $urandom_range(0, 13);
      end
      if (k > 0) begin
        out_stall_i <= 1'b1;
        repeat (k) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // One register write; the caller drops the write enable after the last one.
  task automatic write_gain(logic [2:0] idx, logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx <= apdc_pkg::CFG_YAW_RATE_P) gain_q[idx] = data;
  endtask

  task automatic set_gains(logic [15:0] rp, logic [15:0] rd, logic [15:0] pp,
                           logic [15:0] pd, logic [15:0] yp);
    write_gain(apdc_pkg::CFG_ROLL_P, rp);
    write_gain(apdc_pkg::CFG_ROLL_D, rd);
    write_gain(apdc_pkg::CFG_PITCH_P, pp);
    write_gain(apdc_pkg::CFG_PITCH_D, pd);
    write_gain(apdc_pkg::CFG_YAW_RATE_P, yp);
    // A spare index must leave every gain alone.
    write_gain(CFG_SPARE, 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Sender: random gap, then hold the request until it is taken.
  task automatic send(att_req_t q);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {quat_w_i, quat_x_i, quat_y_i, quat_z_i, rate_x_i, rate_y_i, rate_z_i,
     roll_reference_i, pitch_reference_i, yaw_rate_reference_i} <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Waits until every expected result has arrived, then lets the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] quat_part(int unsigned mode);
    logic signed [15:0] pick [5] = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd16384, -16'sd16384};
    if (mode < 6) return 16'($urandom_range(0, 16383)) - 16'sd8192;
    if (mode < 8) return 16'($urandom);
    return pick[$urandom_range(0, 4)];
  endfunction

  function automatic logic signed [15:0] rate_part();
    if ($urandom_range(0, 1)) return 16'($urandom);
    return 16'($urandom_range(0, 8191)) - 16'sd4096;
  endfunction

  function automatic att_req_t random_req();
    att_req_t q;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    q.qw = quat_part(mode);
    q.qx = quat_part(mode);
    q.qy = quat_part(mode);
    q.qz = quat_part(mode);
    q.wx = rate_part();
    q.wy = rate_part();
    q.wz = rate_part();
    q.roll_ref  = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, 8191)) - 16'sd4096;
    q.pitch_ref = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, 8191)) - 16'sd4096;
    q.yaw_ref   = rate_part();
    return q;
  endfunction

  function automatic att_row_t row(att_req_t q, bit typed, bit sat);
    att_row_t r;
    r.req   = q;
    r.typed = typed;
    r.res   = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, sat};
    return r;
  endfunction

  task automatic walk_table(bit use_typed);
    foreach (dir_rows[i]) begin
      typed_q.push_back(use_typed && dir_rows[i].typed);
      typed_res_q.push_back(dir_rows[i].res);
      send(dir_rows[i].req);
    end
    drain();
  endtask

  // Main sequence: reset, directed table at zero and extreme gains, random phases.
  initial begin
    logic signed [15:0] mx, mn;
    mx = 16'sh7fff;
    mn = 16'sh8000;
    foreach (gain_q[i]) gain_q[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With zero gains every command is zero; the flag comes from the arcsine clamp.
    dir_rows.push_back(row('0, 1, 0));
    dir_rows.push_back(row('{16'sd16384, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0));
    dir_rows.push_back(row('{mn, mn, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 1));
    dir_rows.push_back(row('{mx, mn, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 1));
    dir_rows.push_back(row('{0, 0, mx, mx, 0, 0, 0, 0, 0, 0}, 1, 1));
    dir_rows.push_back(row('{mn, mx, mx, mx, 0, 0, 0, 0, 0, 0}, 1, 1));
    dir_rows.push_back(row('{mx, 0, mx, 0, 0, 0, 0, 0, 0, 0}, 1, 1));
    dir_rows.push_back(row('{mx, 0, mn, 0, 0, 0, 0, 0, 0, 0}, 1, 1));
    dir_rows.push_back(row('{11585, 11585, 0, 0, mx, mn, mx, mx, mn, mx}, 1, 0));
    dir_rows.push_back(row('{11585, 0, 11585, 0, mn, mx, mn, mn, mx, mn}, 1, 0));
    dir_rows.push_back(row('{16384, 0, 0, 0, 0, 0, mx, 3038, -3038, mn}, 1, 0));
    dir_rows.push_back(row('{16384, 0, 0, 0, 0, 0, mn, 3039, -3039, mx}, 1, 0));
    dir_rows.push_back(row('{0, 16384, 0, 0, 2048, -2048, 0, 1000, -1000, 0}, 1, 0));
    dir_rows.push_back(row('{8192, 8192, 8192, 8192, 1, -1, 1, -1, 1, -1}, 1, 0));
    walk_table(1'b1);

    // Same rows at the extreme gains, to drive commands into saturation where errors or rates are not zero.
    set_gains(mx, mx, mx, mx, mx);
    walk_table(1'b0);
    set_gains(mn, mn, mn, mn, mn);
    walk_table(1'b0);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_gains(mx, mn, mn, mx, mx);
        1: set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        2: set_gains(16'sd256, 16'sd64, 16'sd256, 16'sd64, 16'sd128);
        3: set_gains(16'($urandom_range(0, 1023)) - 16'sd512,
                     16'($urandom_range(0, 1023)) - 16'sd512,
                     16'($urandom_range(0, 1023)) - 16'sd512,
                     16'($urandom_range(0, 1023)) - 16'sd512,
                     16'($urandom_range(0, 1023)) - 16'sd512);
        4: set_gains(mn, mx, mx, mn, mn);
        default: set_gains(16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom));
      endcase
      for (int n = 0; n < ITEMS_SET; n++) begin
        if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        // Hold the output long enough for the pipeline to fill and stall the input.
        if (phase == 2 && n == 100) begin
          quiet = 1'b1;
          hold_req = 1'b1;
        end
        send(random_req());
      end
      quiet = 1'b0;
      drain();
    end

    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/apdc_pkg.sv
rtl/core/apdc_asin.sv
rtl/core/attitude_pd_controller_unit.sv
rtl/core/apdc_checker.sv
bench/attitude_pd_controller_unit_tb.sv
